FILE: hdl/srl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srl_pkg: shared types and constants of the sorted record list
// Record layout, result bundle and item mode codes.
// ----------------------------------------------------------------------------
package srl_pkg;

  localparam int DEFAULT_LIST_DEPTH = 64;

  localparam int MINUTE_W = 11;
  localparam int LIGHT_W  = 4;
  localparam int CARS_W   = 10;
  localparam int INDEX_W  = 6;
  localparam int HELD_W   = 7;

  // item modes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  typedef struct packed {
    logic [MINUTE_W-1:0] minute;
    logic [LIGHT_W-1:0]  light;
    logic [CARS_W-1:0]   cars;
  } entry_t;

  typedef struct packed {
    logic                entry_valid;
    logic [MINUTE_W-1:0] minute;
    logic [LIGHT_W-1:0]  light;
    logic [CARS_W-1:0]   cars;
    logic [HELD_W-1:0]   held;
    logic                dropped;
  } res_t;

endpackage

FILE: hdl/srl_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srl_mem: entry storage
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module srl_mem #(
  parameter int LIST_DEPTH = srl_pkg::DEFAULT_LIST_DEPTH,
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  srl_pkg::entry_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output srl_pkg::entry_t rdata
);
  import srl_pkg::*;

  entry_t mem [LIST_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/srl_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srl_seq: list sequencer
// Decodes items, walks the list from the tail shifting entries down one slot
// per cycle, and builds the result.
// ----------------------------------------------------------------------------
module srl_seq #(
  parameter int LIST_DEPTH = srl_pkg::DEFAULT_LIST_DEPTH,
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   mode,
  input  srl_pkg::entry_t              in_rec,
  input  logic [srl_pkg::INDEX_W-1:0]  read_index,
  input  logic                         out_free,
  output logic                         done,
  output srl_pkg::res_t                res,
  output logic                         mem_we,
  output logic [AW-1:0]                mem_waddr,
  output srl_pkg::entry_t              mem_wdata,
  output logic                         mem_re,
  output logic [AW-1:0]                mem_raddr,
  input  srl_pkg::entry_t              mem_rdata
);
  import srl_pkg::*;

  localparam int CW   = $clog2(LIST_DEPTH + 1);
  localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int TW   = (CW > HELD_W) ? CW : HELD_W;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_FULL = 6'b000010,
    ST_WALK = 6'b000100,
    ST_PUT  = 6'b001000,
    ST_RD   = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t         state, state_next;
  logic [AW-1:0]  k, k_next;
  entry_t         rec, rec_next;
  logic [CW-1:0]  total, total_next;
  res_t           res_r, res_next;

  logic [AW-1:0]   km1;
  logic [CMPW-1:0] idx_ext;
  logic            read_hit;
  logic            full;
  logic [TW-1:0]   total_ext;

  assign km1       = k - AW'(1);
  assign idx_ext   = CMPW'(read_index);
  assign read_hit  = (idx_ext < CMPW'(total)) && (idx_ext < CMPW'(LIST_DEPTH));
  assign full      = (total == CW'(LIST_DEPTH));
  assign total_ext = TW'(total);
  assign in_ready  = (state == ST_IDLE);

  always_comb begin
    res      = res_r;
    res.held = total_ext[HELD_W-1:0];
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    rec_next   = rec;
    total_next = total;
    res_next   = res_r;
    mem_we     = 1'b0;
    mem_waddr  = k;
    mem_wdata  = rec;
    mem_re     = 1'b0;
    mem_raddr  = km1;
    done       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          res_next   = '0;
          state_next = ST_FIN;
          case (mode)
            MODE_INSERT: begin
              rec_next = in_rec;
              if (full) begin
                res_next.dropped = 1'b1;
                k_next     = AW'(LIST_DEPTH - 1);
                mem_re     = 1'b1;
                mem_raddr  = AW'(LIST_DEPTH - 1);
                state_next = ST_FULL;
              end else if (total == '0) begin
                k_next     = '0;
                total_next = total + CW'(1);
                state_next = ST_PUT;
              end else begin
                k_next     = total[AW-1:0];
                mem_re     = 1'b1;
                mem_raddr  = total[AW-1:0] - AW'(1);
                total_next = total + CW'(1);
                state_next = ST_WALK;
              end
            end
            MODE_READ: begin
              if (read_hit) begin
                mem_re     = 1'b1;
                mem_raddr  = idx_ext[AW-1:0];
                state_next = ST_RD;
              end
            end
            MODE_CLEAR: begin
              total_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FULL: begin
        // tail entry larger than the new record: the record itself falls out
        if (mem_rdata.cars > rec.cars) begin
          state_next = ST_FIN;
        end else if (k == '0) begin
          state_next = ST_PUT;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = km1;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        // mem_rdata holds entry k-1
        mem_we = 1'b1;
        if (mem_rdata.cars > rec.cars) begin
          state_next = ST_FIN;
        end else begin
          mem_wdata = mem_rdata;
          k_next    = km1;
          if (km1 == '0) begin
            state_next = ST_PUT;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = km1 - AW'(1);
          end
        end
      end
      ST_PUT: begin
        mem_we     = 1'b1;
        state_next = ST_FIN;
      end
      ST_RD: begin
        res_next.entry_valid = 1'b1;
        res_next.minute      = mem_rdata.minute;
        res_next.light       = mem_rdata.light;
        res_next.cars        = mem_rdata.cars;
        state_next           = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          done       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      total <= '0;
    end else begin
      state <= state_next;
      total <= total_next;
    end
    k     <= k_next;
    rec   <= rec_next;
    res_r <= res_next;
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CW'(LIST_DEPTH))
    else $error("entry count above list depth");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_WALK || state == ST_PUT))
    else $error("memory write outside insert walk");

  a_walk_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (k != '0))
    else $error("walk reached slot zero");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> (state == ST_IDLE))
    else $error("sequencer did not return to idle after result");

endmodule

FILE: hdl/sorted_record_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_record_list: traffic records kept sorted by car count
// Insert, read by index and clear on a list held in one synchronous memory.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Signals                     Carries
//  s_*      in   s_tvalid/s_tready/s_tdata   item: mode on s_tuser, record,
//                s_tuser                     read index on s_tdata
//  m_*      out  m_tvalid/m_tready/m_tdata   result: entry_valid on m_tuser,
//                m_tuser                     entry, count, drop flag
//
//  The insert walk moves one entry per cycle through the single memory write
//  port. A read past the end skips the memory fetch; clear and unused modes
//  go straight to the result state.
//  One item is in work at a time; s_tready is high only while idle.
//  Reset (rst, synchronous) empties the list; entry contents are not cleared.
//  A result waiting on m_tready does not block the next transfer in, the
//  sequencer holds its finished result until the output register frees.
//
module sorted_record_list #(
  parameter int LIST_DEPTH = srl_pkg::DEFAULT_LIST_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [10:0] minute_of_day, [14:11] light_number, [24:15] car_count,
  // [30:25] read_index, [31] zero
  input  logic [31:0] s_tdata,
  // [1:0] mode
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [10:0] minute_out, [14:11] light_out, [24:15] cars_out,
  // [31:25] entries_held, [32] dropped, [39:33] zero
  output logic [39:0] m_tdata,
  // [0] entry_valid
  output logic        m_tuser
);
  import srl_pkg::*;

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  entry_t          in_rec;
  logic [INDEX_W-1:0] read_index;
  logic            out_free;
  logic            done;
  res_t            res;
  res_t            out_reg;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  entry_t          mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  entry_t          mem_rdata;

  // unpack the input transfer
  assign in_rec.minute = s_tdata[10:0];
  assign in_rec.light  = s_tdata[14:11];
  assign in_rec.cars   = s_tdata[24:15];
  assign read_index    = s_tdata[30:25];

  // output slot free now or at this edge
  assign out_free = !m_tvalid || m_tready;

  srl_seq #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .mode       (s_tuser),
    .in_rec     (in_rec),
    .read_index (read_index),
    .out_free   (out_free),
    .done       (done),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  srl_mem #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register: loaded when the sequencer finishes, held until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (done) begin
      out_reg <= res;
    end
  end

  assign m_tdata = {7'd0, out_reg.dropped, out_reg.held, out_reg.cars,
                    out_reg.light, out_reg.minute};
  assign m_tuser = out_reg.entry_valid;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sorted_record_list
// Drives insert, read, clear and unused-mode items over the slave stream,
// tracks the sorted list in a local model and checks every master-side
// transfer field by field against the predicted outcome. Directed corner
// cases come first, then three random traffic phases with varying idling.
// ----------------------------------------------------------------------------
module testbench;
  import srl_pkg::*;

  localparam int LIST_DEPTH  = DEFAULT_LIST_DEPTH;
  localparam int CLK_HALF    = 6;
  localparam int CYCLE_LIMIT = 1_000_000;
  // mode code the block leaves unused
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // [10:0] minute_of_day, [14:11] light_number, [24:15] car_count,
  // [30:25] read_index, [31] zero
  logic [31:0] s_tdata = '0;
  // [1:0] mode
  logic [1:0]  s_tuser = MODE_INSERT;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [10:0] minute_out, [14:11] light_out, [24:15] cars_out,
  // [31:25] entries_held, [32] dropped, [39:33] zero
  logic [39:0] m_tdata;
  // [0] entry_valid
  logic        m_tuser;

  // local copy of the list, largest count first
  entry_t list_model [LIST_DEPTH];
  int     held_count = 0;

  // outcomes predicted at input acceptance, oldest first
  res_t   due_results [$];

  int     err_count   = 0;
  int     cycle_count = 0;
  int     src_idle_pct  = 0;
  int     sink_idle_pct = 0;

  sorted_record_list #(.LIST_DEPTH(LIST_DEPTH)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // List model: applies one item and returns the outcome it must produce.
  // --------------------------------------------------------------------------
  function automatic res_t apply_list_op(input logic [1:0] mode, input entry_t rec,
                                         input logic [INDEX_W-1:0] idx);
    res_t r;
    int   pos;
    int   tail_pos;
    int   k;
    r = '0;
    case (mode)
      MODE_INSERT: begin
        // walk past every entry with a strictly larger count
        pos = 0;
        while (pos < held_count && list_model[pos].cars > rec.cars) pos++;
        if (held_count >= LIST_DEPTH) begin
          // full: smallest falls out; if the new record is below every entry,
          // it is the one that falls out and the list stays as it was
          r.dropped = 1'b1;
          tail_pos  = (pos >= LIST_DEPTH) ? -1 : LIST_DEPTH - 1;
        end else begin
          tail_pos = held_count;
          held_count++;
        end
        if (tail_pos >= 0) begin
          for (k = tail_pos; k > pos; k--) list_model[k] = list_model[k-1];
          list_model[pos] = rec;
        end
      end
      MODE_READ: begin
        if (int'(idx) < held_count) begin
          r.entry_valid = 1'b1;
          r.minute      = list_model[idx].minute;
          r.light       = list_model[idx].light;
          r.cars        = list_model[idx].cars;
        end
      end
      MODE_CLEAR: held_count = 0;
      default: ;  // unused mode leaves the list alone
    endcase
    r.held = HELD_W'(held_count);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one item per call. s_tvalid stays high across back-to-back
  // transfers and only drops while the sender idles.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] mode, input entry_t rec,
                           input logic [INDEX_W-1:0] idx);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {1'b0, idx, rec.cars, rec.light, rec.minute};
    do @(posedge clk); while (!s_tready);
    due_results.insert(due_results.size(), apply_list_op(mode, rec, idx));
  endtask

  task automatic insert_rec(input int minute, input int light, input int cars);
    entry_t rec;
    rec.minute = MINUTE_W'(minute);
    rec.light  = LIGHT_W'(light);
    rec.cars   = CARS_W'(cars);
    send_item(MODE_INSERT, rec, INDEX_W'($urandom));
  endtask

  task automatic read_at(input int idx);
    send_item(MODE_READ, entry_t'($urandom), INDEX_W'(idx));
  endtask

  // sender holds off until every predicted outcome has been seen
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test tasks
  // --------------------------------------------------------------------------
  task automatic test_empty_reads();
    read_at(0);
    read_at(63);
  endtask

  // extremes of every field and ties, one of them at the smallest count
  task automatic test_insert_order();
    int i;
    insert_rec(0, 0, 0);
    insert_rec(2047, 15, 1023);   // minute above its range is kept as is
    insert_rec(100, 5, 500);
    insert_rec(200, 6, 500);      // tie: newest goes first
    insert_rec(300, 7, 0);        // tie with the smallest
    for (i = 0; i < 6; i++) read_at(i);  // index 5 is one past the end
  endtask

  task automatic test_odd_modes();
    send_item(MODE_UNUSED, entry_t'($urandom), INDEX_W'($urandom));
    send_item(MODE_CLEAR, entry_t'($urandom), INDEX_W'($urandom));
    read_at(0);                   // stale memory must stay hidden
    insert_rec(1439, 9, 600);
    insert_rec(1, 3, 599);        // strictly smallest goes at the end
    read_at(1);
    read_at(0);
    read_at(2);
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                     input int n_items);
    int     i;
    int     pick;
    entry_t rec;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (i = 0; i < n_items; i++) begin
      pick       = $urandom_range(999);
      rec.minute = MINUTE_W'($urandom);
      rec.light  = LIGHT_W'($urandom);
      // mix tiny, near-max and uniform counts so ties and full-list
      // insertions both show up
      case ($urandom_range(3))
        0:       rec.cars = CARS_W'($urandom_range(3));
        1:       rec.cars = CARS_W'(1023 - $urandom_range(3));
        default: rec.cars = CARS_W'($urandom);
      endcase
      if (pick < 3)
        send_item(MODE_CLEAR, rec, INDEX_W'($urandom));
      else if (pick < 30)
        send_item(MODE_UNUSED, rec, INDEX_W'($urandom));
      else if (pick < 350)
        send_item(MODE_READ, rec, INDEX_W'($urandom));
      else
        send_item(MODE_INSERT, rec, INDEX_W'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Sink side: random back-pressure, result checking
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_results.size() == 0) begin
        $error("transfer out with no outcome due: tdata=%h tuser=%b", m_tdata, m_tuser);
        err_count++;
      end else begin
        want = due_results.pop_front();
        if (m_tuser !== want.entry_valid) begin
          $error("entry_valid: expected %0d, got %0d", want.entry_valid, m_tuser);
          err_count++;
        end
        if (m_tdata[10:0] !== want.minute) begin
          $error("minute_out: expected %0d, got %0d", want.minute, m_tdata[10:0]);
          err_count++;
        end
        if (m_tdata[14:11] !== want.light) begin
          $error("light_out: expected %0d, got %0d", want.light, m_tdata[14:11]);
          err_count++;
        end
        if (m_tdata[24:15] !== want.cars) begin
          $error("cars_out: expected %0d, got %0d", want.cars, m_tdata[24:15]);
          err_count++;
        end
        if (m_tdata[31:25] !== want.held) begin
          $error("entries_held: expected %0d, got %0d", want.held, m_tdata[31:25]);
          err_count++;
        end
        if (m_tdata[32] !== want.dropped) begin
          $error("dropped: expected %0d, got %0d", want.dropped, m_tdata[32]);
          err_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct  = 13;
    sink_idle_pct = 83;
    test_empty_reads();
    test_insert_order();
    test_odd_modes();
    wait_drained();

    test_random_traffic(13, 83, 450);
    wait_drained();
    test_random_traffic(83, 13, 450);
    wait_drained();
    test_random_traffic(0, 0, 450);

    // let the tail settle and catch any stray transfer out
    wait_drained();
    repeat (LIST_DEPTH + 16) @(posedge clk);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sorted_record_list.f
hdl/srl_pkg.sv
hdl/srl_mem.sv
hdl/srl_seq.sv
hdl/sorted_record_list.sv
tb/testbench.sv
